// ----- sv/matrix_inverse_3x3_macros.svh -----
// Assertion macros shared by the matrix inverse modules.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MI3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix inverse check failed");

`define MI3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix inverse check failed");

`else

`define MI3_ASSERT_IMP(lbl, ante, cons)

`define MI3_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- sv/mi3_pkg.sv -----
// Types and constants for the 3x3 matrix inverse.
package mi3_pkg;

  localparam int ELEM_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ADJ_W         = 2 * ELEM_WIDTH + 1;
  localparam int DET_W         = 3 * ELEM_WIDTH + 1;
  localparam int QDEPTH        = 2;

  // cofactor k = e[MA]*e[MB] - e[MC]*e[MD]
  localparam int unsigned MA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned MB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned MC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned MD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  // cofactors paired with the first row for the determinant
  localparam int unsigned CI [3] = '{0, 3, 6};

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [ADJ_W-1:0]      adj_t;
  typedef logic signed [DET_W-1:0]      det_t;

  typedef struct packed {
    elem_t in_r0c0;
    elem_t in_r0c1;
    elem_t in_r0c2;
    elem_t in_r1c0;
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r2c0;
    elem_t in_r2c1;
    elem_t in_r2c2;
  } mi3_in_t;

  typedef struct packed {
    elem_t out_r0c0;
    elem_t out_r0c1;
    elem_t out_r0c2;
    elem_t out_r1c0;
    elem_t out_r1c1;
    elem_t out_r1c2;
    elem_t out_r2c0;
    elem_t out_r2c1;
    elem_t out_r2c2;
    logic  singular;
    logic  saturated;
  } mi3_out_t;

  typedef struct packed {
    logic [8:0][ADJ_W-1:0] adj;
    det_t                  det;
  } mi3_job_t;

  typedef struct packed {
    logic     vld;
    mi3_job_t job;
  } mi3_xfer_t;

endpackage

// ----- sv/mi3_front.sv -----
// Front end: input register, cofactors and determinant pipeline.
module mi3_front
  import mi3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mi3_in_t   in_data,
  output mi3_xfer_t fq_o,
  input  logic      take_i
);

  localparam int NS = 6;

  logic [NS-1:0] vld_r;
  logic          en;

  elem_t                       e0_r [9];
  elem_t                       e1_r [3];
  elem_t                       e2_r [3];
  logic signed [2*ELEM_WIDTH-1:0] pa_r [9];
  logic signed [2*ELEM_WIDTH-1:0] pb_r [9];
  adj_t                        cof_r [9];
  adj_t                        cof3_r [9];
  adj_t                        cof4_r [9];
  adj_t                        cof5_r [9];
  logic signed [2*ELEM_WIDTH:0] ph_r [3];
  logic signed [2*ELEM_WIDTH:0] pl_r [3];
  det_t                        term_r [3];
  det_t                        det_r;

  assign en       = !vld_r[NS-1] || take_i;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_r[0] <= in_data.in_r0c0;
      e0_r[1] <= in_data.in_r0c1;
      e0_r[2] <= in_data.in_r0c2;
      e0_r[3] <= in_data.in_r1c0;
      e0_r[4] <= in_data.in_r1c1;
      e0_r[5] <= in_data.in_r1c2;
      e0_r[6] <= in_data.in_r2c0;
      e0_r[7] <= in_data.in_r2c1;
      e0_r[8] <= in_data.in_r2c2;
      for (int k = 0; k < 9; k++) begin
        pa_r[k]   <= e0_r[MA[k]] * e0_r[MB[k]];
        pb_r[k]   <= e0_r[MC[k]] * e0_r[MD[k]];
        cof_r[k]  <= ADJ_W'(pa_r[k]) - ADJ_W'(pb_r[k]);
        cof3_r[k] <= cof_r[k];
        cof4_r[k] <= cof3_r[k];
        cof5_r[k] <= cof4_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        e1_r[j]   <= e0_r[j];
        e2_r[j]   <= e1_r[j];
        ph_r[j]   <= e2_r[j] * $signed(cof_r[CI[j]][ADJ_W-1:ELEM_WIDTH]);
        pl_r[j]   <= e2_r[j] * $signed({1'b0, cof_r[CI[j]][ELEM_WIDTH-1:0]});
        term_r[j] <= (DET_W'(ph_r[j]) <<< ELEM_WIDTH) + DET_W'(pl_r[j]);
      end
      det_r <= term_r[0] + term_r[1] + term_r[2];
    end
  end

  always_comb begin
    fq_o.vld     = vld_r[NS-1];
    fq_o.job.det = det_r;
    for (int k = 0; k < 9; k++) begin
      fq_o.job.adj[k] = cof5_r[k];
    end
  end

endmodule

// ----- sv/mi3_queue.sv -----
// Two-entry queue between the front end and the divider back end.
`include "matrix_inverse_3x3_macros.svh"
module mi3_queue
  import mi3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mi3_xfer_t fq_i,
  output logic      take_o,
  output mi3_xfer_t q_o,
  input  logic      pop_i
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  mi3_job_t      mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          pop;
  logic          full;

  assign full   = cnt_r == CW'(QDEPTH);
  assign pop    = (cnt_r != '0) && pop_i;
  assign take_o = !full || pop;
  assign push   = fq_i.vld && take_o;

  assign q_o.vld = cnt_r != '0;
  assign q_o.job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= fq_i.job;
    end
  end

  `MI3_ASSERT_IMP(a_q_bound, 1'b1, cnt_r <= CW'(QDEPTH))

endmodule

// ----- sv/mi3_back.sv -----
// Back end: rounding divider pipeline, saturation and output register.
`include "matrix_inverse_3x3_macros.svh"
module mi3_back
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mi3_xfer_t q_i,
  output logic      take_o,
  output logic      out_valid,
  input  logic      out_ready,
  output mi3_out_t  out_data
);

  localparam int QW = ELEM_WIDTH + 1;
  localparam int NM = (2 * ELEM_WIDTH + 2 * FRAC_BITS > 3 * ELEM_WIDTH) ?
                      2 * ELEM_WIDTH + 2 * FRAC_BITS : 3 * ELEM_WIDTH;
  localparam int NW = NM + 2;
  localparam int XW = NW + QW + 1;
  localparam int NB = QW + 3;

  logic [NB-1:0] vld_r;
  logic          en;

  logic [XW-1:0] num_nxt [9];
  logic [XW-1:0] den_nxt;
  logic [8:0]    neg_nxt;
  logic          det_neg;
  logic [DET_W-1:0] det_mag;

  logic [XW-1:0] num_b0_r [9];
  logic [XW-1:0] den_b0_r;
  logic [8:0]    neg_b0_r;
  logic          sing_b0_r;

  logic [XW-1:0] rem_r  [QW][9];
  logic [XW-1:0] den_r  [QW];
  logic [QW-1:0] q_r    [QW+1][9];
  logic [8:0]    over_r [QW+1];
  logic [8:0]    neg_r  [QW+1];
  logic [QW:0]   sing_r;

  logic [XW-1:0] dsh_c [QW];
  logic          ge_c  [QW][9];

  elem_t         res_c [9];
  logic [8:0]    clamp_c;
  mi3_out_t      out_nxt;
  mi3_out_t      out_data_r;

  assign en        = !vld_r[NB-1] || out_ready;
  assign take_o    = en;
  assign out_valid = vld_r[NB-1];
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NB-2:0], q_i.vld};
    end
  end

  always_comb begin
    logic signed [ADJ_W-1:0] adj_s;
    logic [ADJ_W-1:0]        amag;
    det_neg = q_i.job.det[DET_W-1];
    det_mag = det_neg ? -q_i.job.det : q_i.job.det;
    den_nxt = XW'(det_mag) << 1;
    for (int k = 0; k < 9; k++) begin
      adj_s      = $signed(q_i.job.adj[k]);
      amag       = adj_s[ADJ_W-1] ? -adj_s : adj_s;
      neg_nxt[k] = adj_s[ADJ_W-1] ^ det_neg;
      num_nxt[k] = (XW'(amag) << (2 * FRAC_BITS + 1)) + XW'(det_mag);
    end
  end

  always_comb begin
    for (int s = 1; s <= QW; s++) begin
      dsh_c[s-1] = den_r[s-1] << (QW - s);
      for (int k = 0; k < 9; k++) begin
        ge_c[s-1][k] = rem_r[s-1][k] >= dsh_c[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_b0_r  <= num_nxt;
      den_b0_r  <= den_nxt;
      neg_b0_r  <= neg_nxt;
      sing_b0_r <= q_i.job.det == '0;

      for (int k = 0; k < 9; k++) begin
        rem_r[0][k]  <= num_b0_r[k];
        q_r[0][k]    <= '0;
        over_r[0][k] <= num_b0_r[k] >= (den_b0_r << QW);
      end
      den_r[0]  <= den_b0_r;
      neg_r[0]  <= neg_b0_r;
      sing_r[0] <= sing_b0_r;

      for (int s = 1; s <= QW; s++) begin
        for (int k = 0; k < 9; k++) begin
          if (s < QW) begin
            rem_r[s][k] <= ge_c[s-1][k] ? rem_r[s-1][k] - dsh_c[s-1] : rem_r[s-1][k];
          end
          q_r[s][k] <= q_r[s-1][k] | (ge_c[s-1][k] ? (QW'(1) << (QW - s)) : '0);
        end
        if (s < QW) begin
          den_r[s] <= den_r[s-1];
        end
        over_r[s] <= over_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        sing_r[s] <= sing_r[s-1];
      end

      out_data_r <= out_nxt;
    end
  end

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] m;
    logic [QW-1:0] nm;
    for (int k = 0; k < 9; k++) begin
      lim = neg_r[QW][k] ? (QW'(1) << (ELEM_WIDTH - 1))
                         : (QW'(1) << (ELEM_WIDTH - 1)) - 1'b1;
      clamp_c[k] = over_r[QW][k] || (q_r[QW][k] > lim);
      m  = clamp_c[k] ? lim : q_r[QW][k];
      nm = -m;
      res_c[k] = sing_r[QW] ? '0 : (neg_r[QW][k] ? $signed(nm[ELEM_WIDTH-1:0])
                                                 : $signed(m[ELEM_WIDTH-1:0]));
    end
    out_nxt.out_r0c0  = res_c[0];
    out_nxt.out_r0c1  = res_c[1];
    out_nxt.out_r0c2  = res_c[2];
    out_nxt.out_r1c0  = res_c[3];
    out_nxt.out_r1c1  = res_c[4];
    out_nxt.out_r1c2  = res_c[5];
    out_nxt.out_r2c0  = res_c[6];
    out_nxt.out_r2c1  = res_c[7];
    out_nxt.out_r2c2  = res_c[8];
    out_nxt.singular  = sing_r[QW];
    out_nxt.saturated = !sing_r[QW] && (clamp_c != '0);
  end

  `MI3_ASSERT_IMP(a_sing_no_sat, out_valid && out_data.singular, !out_data.saturated)
  `MI3_ASSERT_IMP(a_sing_zero, out_valid && out_data.singular, out_data.out_r0c0 == '0 && out_data.out_r1c1 == '0 && out_data.out_r2c2 == '0)
  `MI3_ASSERT_NXT(a_advance, vld_r[NB-2] && en, out_valid)

endmodule

// ----- sv/matrix_inverse_3x3.sv -----
// Top level of the 3x3 fixed-point matrix inverse.
// Throughput: one item per cycle when neither side stalls; the bit-per-stage divider pipeline sets the depth.
// Back-pressure stalls each side separately through a two-entry queue.
// Reset: synchronous, active low; clears all valid bits and the queue.
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mi3_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mi3_out_t out_data
);

  mi3_xfer_t fq;
  mi3_xfer_t qb;
  logic      q_take;
  logic      b_take;

  mi3_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fq_o     (fq),
    .take_i   (q_take)
  );

  mi3_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .fq_i   (fq),
    .take_o (q_take),
    .q_o    (qb),
    .pop_i  (b_take)
  );

  mi3_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_i       (qb),
    .take_o    (b_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- dv/tb.sv -----
// Testbench for matrix_inverse_3x3: random and directed matrices against a Q16.16 predictor.
module tb
  import mi3_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int ONE            = 65536;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  mi3_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mi3_out_t out_data;

  mi3_in_t  pending_items[$];
  mi3_out_t expected_inverses[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       recv_hold_cycles = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  logic     in_taken = 1'b0;

  matrix_inverse_3x3 DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic mi3_out_t invert(mi3_in_t m);
    logic signed [199:0] e[9];
    logic signed [199:0] cof[9];
    logic signed [199:0] det;
    logic [199:0]        dmag, amag, quo, lim;
    logic                neg, sat;
    logic [8:0][31:0]    el;
    e[0] = m.in_r0c0; e[1] = m.in_r0c1; e[2] = m.in_r0c2;
    e[3] = m.in_r1c0; e[4] = m.in_r1c1; e[5] = m.in_r1c2;
    e[6] = m.in_r2c0; e[7] = m.in_r2c1; e[8] = m.in_r2c2;
    cof[0] = e[4] * e[8] - e[5] * e[7];
    cof[1] = e[2] * e[7] - e[1] * e[8];
    cof[2] = e[1] * e[5] - e[2] * e[4];
    cof[3] = e[5] * e[6] - e[3] * e[8];
    cof[4] = e[0] * e[8] - e[2] * e[6];
    cof[5] = e[2] * e[3] - e[0] * e[5];
    cof[6] = e[3] * e[7] - e[4] * e[6];
    cof[7] = e[1] * e[6] - e[0] * e[7];
    cof[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
    if (det == 0) begin
      return {288'b0, 1'b1, 1'b0};
    end
    dmag = (det < 0) ? -det : det;
    sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      amag = (cof[k] < 0) ? -cof[k] : cof[k];
      neg = (cof[k] < 0) != (det < 0);
      quo = ((amag << 33) + dmag) / (dmag << 1);
      lim = neg ? 200'h8000_0000 : 200'h7fff_ffff;
      if (quo > lim) begin
        quo = lim;
        sat = 1'b1;
      end
      el[8-k] = neg ? -quo[31:0] : quo[31:0];
    end
    return {el, 1'b0, sat};
  endfunction

  function automatic mi3_in_t matrix(int a, int b, int c, int d, int e, int f,
                                     int g, int h, int i);
    return {a, b, c, d, e, f, g, h, i};
  endfunction

  function automatic int small_elem();
    return int'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  function automatic mi3_in_t random_matrix();
    mi3_in_t m;
    int      kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      m = matrix(small_elem(), small_elem(), small_elem(), small_elem(), small_elem(),
                 small_elem(), small_elem(), small_elem(), small_elem());
    end else if (kind < 75) begin
      m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    end else if (kind < 87) begin
      m = matrix(small_elem(), small_elem(), small_elem(), small_elem(), small_elem(),
                 small_elem(), 0, 0, 0);
      if ($urandom_range(0, 1)) begin
        m.in_r2c0 = m.in_r0c0; m.in_r2c1 = m.in_r0c1; m.in_r2c2 = m.in_r0c2;
      end
    end else begin
      m = matrix($urandom_range(0, 3) - 1, 0, 0, 0, $urandom_range(0, 3) - 1, 0, 0, 0,
                 $urandom);
      m.in_r0c0 = m.in_r0c0 * ($urandom_range(0, 1) ? 1 : $urandom_range(1, 1 << 24));
      m.in_r1c1 = m.in_r1c1 * ($urandom_range(1, 1 << 18));
    end
    return m;
  endfunction

  // drive the input side
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // drive the result side
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles <= recv_hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
      end
    end
  end

  // sample both sides
  always @(posedge clk) begin
    mi3_out_t         want;
    logic [8:0][31:0] we, ge;
    logic             bad;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_inverses.push_back(invert(in_data));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_inverses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = expected_inverses.pop_front();
          we = want[289:2];
          ge = out_data[289:2];
          bad = (want.singular !== out_data.singular) ||
                (want.saturated !== out_data.saturated);
          for (int k = 0; k < 9; k++) bad |= (we[k] !== ge[k]);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %h got %h", want, out_data);
          end
        end
      end
      quiet_cycles = (in_taken || (out_valid && out_ready)) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_inverses.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 45, 0, 7};
    recv_pct = '{0, 0, 45, 7};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pending_items.push_back(matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    pending_items.push_back(matrix(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    pending_items.push_back(matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(matrix(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                                   7 * ONE, 8 * ONE, 9 * ONE));
    pending_items.push_back(matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_items.push_back(matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_items.push_back(matrix(32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0, 0, 0,
                                   32'sh7fffffff));
    pending_items.push_back(matrix(32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0,
                                   32'sh80000000));
    pending_items.push_back({9{32'h80000000}});
    pending_items.push_back({9{32'h7fffffff}});
    pending_items.push_back(matrix(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff,
                                   32'sh80000000, 0, 0, 0, 32'sh7fffffff));
    pending_items.push_back(matrix(0, 0, -ONE, 0, 1, 0, 2 * ONE, 0, 1));
    pending_items.push_back(matrix(0, 0, ONE, 0, 1, 0, 2 * ONE, 0, 1));
    pending_items.push_back(matrix(3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, -3 * ONE));
    pending_items.push_back(matrix(2 * ONE, ONE, 0, ONE, 2 * ONE, ONE, 0, ONE, 2 * ONE));
    pending_items.push_back(matrix(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
    pending_items.push_back({9{32'hffffffff}});
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 2) recv_hold_cycles = 300;
      for (int n = 0; n < 135; n++) pending_items.push_back(random_matrix());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_inverses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
